// ----- design/ibv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_pkg
// Shared types and constants of the IMU bias and variance calibrator.
// ----------------------------------------------------------------------------
package ibv_pkg;

  localparam int unsigned IN_AXES     = 6;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned STAT_W      = 49;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned DIVISOR_W   = 25;
  localparam int unsigned DIVIDEND_W  = 64;
  localparam int unsigned GYRO_DIV    = 500;
  localparam int unsigned GYRO_FIRST  = 3;
  localparam logic [CNT_W-1:0] COUNT_RESET = 16'd3000;

  // ceil(2^37 / 125): floor(|g| * 2^16 / 500) == (|g| * GYRO_RECIP) >> GYRO_RECIP_SH
  // for every |g| up to 2^15.
  localparam logic [30:0] GYRO_RECIP    = 31'd1099511628;
  localparam int unsigned GYRO_RECIP_SH = 23;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam logic KIND_MEAN   = 1'b0;
  localparam logic KIND_VAR    = 1'b1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    L_IDLE,
    L_SCALE,
    L_ROUND,
    L_DIFF,
    L_MHH,
    L_MHL,
    L_MLL,
    L_MADD,
    L_ACC,
    L_FIN_MEAN,
    L_FIN_VAR
  } lane_state_e;

  // Per-sample request broadcast to every lane.
  typedef struct packed {
    logic             start;
    logic             clear;
    logic             phase;
    logic             fin;
    logic [CNT_W-1:0] n;
  } lane_cmd_t;

endpackage

// ----- design/ibv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_in_if / ibv_out_if
// Valid/ready channels for samples in and statistics out.
// ----------------------------------------------------------------------------
interface ibv_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;

  modport source (output valid, command, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, input ready);
  modport sink (input valid, command, accel_x, accel_y, accel_z,
                gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface ibv_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [48:0] accel_x_stat;
  logic signed [48:0] accel_y_stat;
  logic signed [48:0] accel_z_stat;
  logic signed [48:0] gyro_x_stat;
  logic signed [48:0] gyro_y_stat;
  logic signed [48:0] gyro_z_stat;

  modport source (output valid, result_kind, accel_x_stat, accel_y_stat,
                  accel_z_stat, gyro_x_stat, gyro_y_stat, gyro_z_stat,
                  input ready);
  modport sink (input valid, result_kind, accel_x_stat, accel_y_stat,
                accel_z_stat, gyro_x_stat, gyro_y_stat, gyro_z_stat,
                output ready);
endinterface

// ----- design/ibv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module ibv_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ibv_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [ibv_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                              done_o,
  output logic [ibv_pkg::DIVIDEND_W-1:0]    quot_o,
  output logic                              rem_nz_o
);
  import ibv_pkg::*;

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic                    busy_q;
  logic [CW-1:0]           cnt_q;
  logic [DIVIDEND_W-1:0]   quo_q;
  logic [DIVISOR_W-1:0]    rem_q;
  logic [DIVISOR_W-1:0]    dvs_q;
  logic [DIVISOR_W:0]      trial;
  logic                    fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
    end
  end

  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// ----- design/ibv_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_lane
// One axis: sums, mean, squared deviations, and end-of-pass division.
// ----------------------------------------------------------------------------
module ibv_lane #(
  parameter bit IS_GYRO = 1'b0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ibv_pkg::lane_cmd_t              cmd_i,
  input  logic signed [ibv_pkg::RAW_W-1:0] raw_i,
  output logic                            done_o,
  output logic [ibv_pkg::STAT_W-1:0]      stat_o
);
  import ibv_pkg::*;

  lane_state_e state_q, state_d;

  logic signed [32:0] raw_sum_q;
  logic signed [31:0] mean_q;
  logic [63:0]        sq_sum_q;
  logic signed [32:0] s_q;
  logic [32:0]        ad_q;
  logic [33:0]        prod_q;
  logic [63:0]        acc_q;
  logic               neg_q;
  logic               fin_q;
  logic [CNT_W-1:0]   n_q;
  logic [STAT_W-1:0]  stat_q;
  logic [16:0]        gmag_q;
  logic [47:0]        recip_q;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dvd;
  logic [DIVISOR_W-1:0]  div_dvs;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                  div_rnz;

  logic signed [32:0] sum_new;
  logic [32:0]        sum_mag;
  logic [16:0]        raw_mag;
  logic [DIVISOR_W-1:0] n_div;
  logic [63:0]        q_signed;
  logic signed [33:0] diff;
  logic [63:0]        sq_new;
  logic signed [31:0] mean_sat;
  logic [16:0]        op_a, op_b;
  logic [24:0]        scl_quo;
  logic [32:0]        scl_mag;
  logic               scl_nz;
  logic [32:0]        scl_s;

  assign sum_new = raw_sum_q + 33'(raw_i);
  assign sum_mag = sum_new[32] ? 33'(-sum_new) : 33'(sum_new);
  assign raw_mag = raw_i[RAW_W-1] ? 17'(-18'(raw_i)) : 17'(raw_i);
  assign n_div   = IS_GYRO ? DIVISOR_W'(DIVISOR_W'(cmd_i.n) * DIVISOR_W'(GYRO_DIV))
                           : DIVISOR_W'(cmd_i.n);
  // Floored signed quotient: -(q+1) when the remainder is nonzero.
  assign q_signed = neg_q ? (div_rnz ? ~div_quo : 64'(-div_quo)) : div_quo;
  assign diff     = 34'(s_q) - 34'(mean_q);
  assign sq_new   = sq_sum_q + {16'b0, acc_q[63:16]};

  // Gyro scaling by 1/500 through the reciprocal; floor toward minus
  // infinity when the magnitude does not divide evenly.
  assign scl_quo = recip_q[47:GYRO_RECIP_SH];
  assign scl_mag = {8'b0, scl_quo};
  assign scl_nz  = (33'(scl_quo) * 33'(GYRO_DIV)) != {gmag_q, 16'b0};
  assign scl_s   = neg_q ? (scl_nz ? ~scl_mag : 33'(-scl_mag)) : scl_mag;

  always_comb begin
    if ($signed(q_signed) > 64'sd2147483647) begin
      mean_sat = 32'sh7fffffff;
    end else if ($signed(q_signed) < -64'sd2147483648) begin
      mean_sat = 32'sh80000000;
    end else begin
      mean_sat = q_signed[31:0];
    end
  end

  always_comb begin
    unique case (state_q)
      L_MHH:   begin op_a = ad_q[32:16]; op_b = ad_q[32:16]; end
      L_MHL:   begin op_a = ad_q[32:16]; op_b = {1'b0, ad_q[15:0]}; end
      default: begin op_a = {1'b0, ad_q[15:0]}; op_b = {1'b0, ad_q[15:0]}; end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    done_o    = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (cmd_i.start && !cmd_i.clear) begin
          if (!cmd_i.phase) begin
            if (cmd_i.fin) begin
              div_start = 1'b1;
              div_dvd   = {15'b0, sum_mag, 16'b0};
              div_dvs   = n_div;
              state_d   = L_FIN_MEAN;
            end else begin
              done_o = 1'b1;
            end
          end else if (IS_GYRO) begin
            state_d = L_SCALE;
          end else begin
            state_d = L_DIFF;
          end
        end
      end
      L_SCALE:    state_d = L_ROUND;
      L_ROUND:    state_d = L_DIFF;
      L_DIFF:     state_d = L_MHH;
      L_MHH:      state_d = L_MHL;
      L_MHL:      state_d = L_MLL;
      L_MLL:      state_d = L_MADD;
      L_MADD:     state_d = L_ACC;
      L_ACC: begin
        if (fin_q) begin
          div_start = 1'b1;
          div_dvd   = sq_new;
          div_dvs   = DIVISOR_W'(n_q);
          state_d   = L_FIN_VAR;
        end else begin
          done_o  = 1'b1;
          state_d = L_IDLE;
        end
      end
      L_FIN_MEAN, L_FIN_VAR: begin
        if (div_done) begin
          done_o  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= L_IDLE;
      raw_sum_q <= '0;
      mean_q    <= '0;
      sq_sum_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_i.start && cmd_i.clear) begin
        state_q   <= L_IDLE;
        raw_sum_q <= '0;
        mean_q    <= '0;
        sq_sum_q  <= '0;
      end else begin
        if (state_q == L_IDLE && cmd_i.start && !cmd_i.phase) begin
          raw_sum_q <= cmd_i.fin ? '0 : sum_new;
        end
        if (state_q == L_FIN_MEAN && div_done) begin
          mean_q <= mean_sat;
        end
        if (state_q == L_ACC) begin
          sq_sum_q <= fin_q ? '0 : sq_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 34'(op_a) * 34'(op_b);
    unique case (state_q)
      L_IDLE: begin
        fin_q <= cmd_i.fin;
        n_q   <= cmd_i.n;
        if (cmd_i.start) begin
          neg_q  <= cmd_i.phase ? raw_i[RAW_W-1] : sum_new[32];
          s_q    <= {raw_i[RAW_W-1], raw_i, 16'b0};
          gmag_q <= raw_mag;
        end
      end
      L_SCALE:  recip_q <= 48'(gmag_q) * 48'(GYRO_RECIP);
      L_ROUND:  s_q <= scl_s;
      L_DIFF:   ad_q <= diff[33] ? 33'(-diff) : 33'(diff);
      L_MHL:    acc_q <= {prod_q[31:0], 32'b0};
      L_MLL:    acc_q <= acc_q + ({30'b0, prod_q} << 17);
      L_MADD:   acc_q <= acc_q + {30'b0, prod_q};
      L_FIN_MEAN: if (div_done) stat_q <= STAT_W'(mean_sat);
      L_FIN_VAR:  if (div_done) stat_q <= div_quo[STAT_W-1:0];
      default: ;
    endcase
  end

  assign stat_o = stat_q;

  ibv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_nz_o   (div_rnz)
  );

endmodule

// ----- design/ibv_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_merge
// Gathers the lane statistics into the registered result channel.
// ----------------------------------------------------------------------------
module ibv_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           kind_i,
  input  logic [ibv_pkg::STAT_W-1:0]     stats_i [ibv_pkg::IN_AXES],
  output logic                           free_o,
  ibv_out_if.source                      res_o
);
  import ibv_pkg::*;

  logic              valid_q;
  logic              kind_q;
  logic [STAT_W-1:0] stat_q [IN_AXES];

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_i;
      stat_q <= stats_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.result_kind  = kind_q;
  assign res_o.accel_x_stat = stat_q[0];
  assign res_o.accel_y_stat = stat_q[1];
  assign res_o.accel_z_stat = stat_q[2];
  assign res_o.gyro_x_stat  = stat_q[3];
  assign res_o.gyro_y_stat  = stat_q[4];
  assign res_o.gyro_z_stat  = stat_q[5];

endmodule

// ----- design/imu_bias_variance_calibrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_variance_calibrator
// Two-pass per-axis mean and variance of six-axis IMU samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per IMU sample (accel xyz, gyro xyz) or a
//   restart command. res_o carries one result at the end of each pass:
//   Q16.16 means after the first N samples, Q32.16 variances after the next N.
//   cfg_we_i/cfg_data_i write N (sample_count) while the block is idle.
// Sequence:
//   One request at a time. A variance sample is paced by the gyro lanes,
//   which run reciprocal scaling by 1/500 ahead of the split square and
//   accumulate. The last sample of a pass adds one 64-step serial division
//   by N (500*N on gyro means); the result then waits out any output stall.
//   A restart gives no result.
// Reset:
//   All sums, means and the pass phase clear; N returns to 3000.
// Stall:
//   The result sits in an output register; the next pass keeps running and
//   only a new result waits for that register to drain, holding off requests.
// ----------------------------------------------------------------------------
module imu_bias_variance_calibrator #(
  parameter int unsigned AXES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  ibv_in_if.sink      req_i,
  ibv_out_if.source   res_o
);
  import ibv_pkg::*;

  top_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] seen_q;
  logic             phase_q;
  logic             fin_q;
  logic             kind_q;
  logic [AXES-1:0]  done_q;
  logic             restart_q;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W:0]   seen_inc;
  logic             accept;
  logic             fin_now;
  logic             all_done;
  logic             out_free;
  logic             load;
  lane_cmd_t        cmd;

  logic signed [RAW_W-1:0] raw_in [IN_AXES];
  logic [AXES-1:0]         lane_done;
  logic [STAT_W-1:0]       lane_stat [AXES];
  logic [STAT_W-1:0]       merge_stat [IN_AXES];

  // Zero count behaves as one.
  assign n_eff    = (count_q == '0) ? CNT_W'(1) : count_q;
  assign seen_inc = {1'b0, seen_q} + 1'b1;
  assign fin_now  = seen_inc >= {1'b0, n_eff};
  assign accept   = req_i.valid && req_i.ready;
  assign all_done = &(done_q | lane_done);

  assign req_i.ready = (state_q == T_IDLE);

  assign raw_in[0] = req_i.accel_x;
  assign raw_in[1] = req_i.accel_y;
  assign raw_in[2] = req_i.accel_z;
  assign raw_in[3] = req_i.gyro_x;
  assign raw_in[4] = req_i.gyro_y;
  assign raw_in[5] = req_i.gyro_z;

  always_comb begin
    cmd.start = accept;
    cmd.clear = req_i.command == CMD_RESTART;
    cmd.phase = phase_q;
    cmd.fin   = fin_now;
    cmd.n     = n_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Sample counter and pass phase advance as each sample is taken; a restart clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      phase_q <= KIND_MEAN;
      fin_q   <= 1'b0;
      kind_q  <= KIND_MEAN;
    end else if (accept) begin
      if (req_i.command == CMD_RESTART) begin
        seen_q  <= '0;
        phase_q <= KIND_MEAN;
        fin_q   <= 1'b0;
      end else begin
        fin_q  <= fin_now;
        kind_q <= phase_q;
        if (fin_now) begin
          seen_q  <= '0;
          phase_q <= !phase_q;
        end else begin
          seen_q <= seen_inc[CNT_W-1:0];
        end
      end
    end
  end

  // Lanes finish at different times; hold each done until all are in.
  // A mean-pass sample finishes in the accept cycle itself, so that cycle
  // is collected too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == T_RUN && !all_done) || accept) begin
        done_q <= done_q | lane_done;
      end else begin
        done_q <= '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      T_IDLE: if (accept) state_d = T_RUN;
      T_RUN: begin
        if (all_done) begin
          state_d = fin_q ? T_OUT : T_IDLE;
        end
      end
      T_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // A restart produces no lane done; the lanes clear in the accept cycle.
  // Mask it in so the controller returns to idle right away.
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    logic signed [RAW_W-1:0] raw;
    logic                    ldone;
    if (i < IN_AXES) begin : g_in
      assign raw = raw_in[i];
    end else begin : g_zero
      assign raw = '0;
    end
    ibv_lane #(
      .IS_GYRO (i >= GYRO_FIRST)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .raw_i  (raw),
      .done_o (ldone),
      .stat_o (lane_stat[i])
    );
    assign lane_done[i] = ldone || restart_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b0;
    end else begin
      restart_q <= accept && req_i.command == CMD_RESTART;
    end
  end

  for (genvar j = 0; j < IN_AXES; j++) begin : g_out
    if (j < AXES) begin : g_used
      assign merge_stat[j] = lane_stat[j];
    end else begin : g_none
      assign merge_stat[j] = '0;
    end
  end

  ibv_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .kind_i  (kind_q),
    .stats_i (merge_stat),
    .free_o  (out_free),
    .res_o   (res_o)
  );

endmodule

// ----- tb/ibv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibv_checker
// Watches the sample and statistics channels and the count register port.
// It predicts the mean and variance results and compares each delivered
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ibv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  ibv_in_if           req,
  ibv_out_if          res,
  output int          fail_count_o,
  output int          pending_o
);
  import ibv_pkg::*;

  typedef struct packed {
    logic                 kind;
    logic [5:0][STAT_W-1:0] stat;
  } calib_stat_t;

  calib_stat_t stat_q[$];

  logic [CNT_W-1:0]  count_reg;
  bit                in_var_pass;
  int unsigned       seen;
  longint            axis_sum [6];
  longint            axis_mean[6];
  longint unsigned   sq_sum   [6];
  int                fails;
  int                pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  task automatic clear_sums();
    in_var_pass = 0;
    seen = 0;
    for (int i = 0; i < 6; i++) begin
      axis_sum[i] = 0;
      axis_mean[i] = 0;
      sq_sum[i] = 0;
    end
  endtask

  task automatic predict_sample(logic cmd, longint raw [6]);
    longint          n;
    longint          m;
    longint          s;
    longint          d;
    longint unsigned ad;
    calib_stat_t     e;
    n = (count_reg == 0) ? 1 : longint'(count_reg);
    if (cmd == CMD_RESTART) begin
      clear_sums();
      return;
    end
    if (!in_var_pass) begin
      for (int i = 0; i < 6; i++) axis_sum[i] += raw[i];
      seen++;
      if (longint'(seen) < n) return;
      for (int i = 0; i < 6; i++) begin
        m = floor_div(axis_sum[i] * 65536, (i >= GYRO_FIRST) ? n * GYRO_DIV : n);
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        axis_mean[i] = m;
        e.stat[i] = m[STAT_W-1:0];
        axis_sum[i] = 0;
      end
      e.kind = KIND_MEAN;
      seen = 0;
      in_var_pass = 1;
      stat_q.push_back(e);
      return;
    end
    for (int i = 0; i < 6; i++) begin
      s = raw[i] * 65536;
      if (i >= GYRO_FIRST) s = floor_div(s, GYRO_DIV);
      d = s - axis_mean[i];
      ad = (d < 0) ? longint'(-d) : longint'(d);
      sq_sum[i] += (ad * ad) >> 16;
    end
    seen++;
    if (longint'(seen) < n) return;
    for (int i = 0; i < 6; i++) begin
      e.stat[i] = STAT_W'(sq_sum[i] / longint'(n));
      sq_sum[i] = 0;
    end
    e.kind = KIND_VAR;
    seen = 0;
    in_var_pass = 0;
    stat_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint      raw [6];
    calib_stat_t e;
    calib_stat_t got;
    if (!rst_ni) begin
      count_reg = COUNT_RESET;
      clear_sums();
      stat_q.delete();
      fails = 0;
      pend = 0;
    end else begin
      if (req.valid && req.ready) begin
        raw[0] = req.accel_x; raw[1] = req.accel_y; raw[2] = req.accel_z;
        raw[3] = req.gyro_x;  raw[4] = req.gyro_y;  raw[5] = req.gyro_z;
        predict_sample(req.command, raw);
      end
      if (res.valid && res.ready) begin
        got.kind = res.result_kind;
        got.stat[0] = res.accel_x_stat; got.stat[1] = res.accel_y_stat;
        got.stat[2] = res.accel_z_stat; got.stat[3] = res.gyro_x_stat;
        got.stat[4] = res.gyro_y_stat;  got.stat[5] = res.gyro_z_stat;
        if (stat_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result kind %0d", $time, got.kind);
        end else begin
          e = stat_q.pop_front();
          if (e.kind !== got.kind) begin
            fails++;
            $display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
          end
          for (int i = 0; i < 6; i++)
            if (e.stat[i] !== got.stat[i]) begin
              fails++;
              $display("%0t: axis %0d exp %h got %h", $time, i, e.stat[i], got.stat[i]);
            end
        end
      end
      if (cfg_we_i) count_reg = cfg_data_i;
      pend = stat_q.size();
    end
  end

endmodule

// ----- tb/imu_bias_variance_calibrator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_variance_calibrator_tb
// Drives directed and random IMU samples, restarts and count changes into
// the calibrator with random gaps and output stalls; the checker predicts
// and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module imu_bias_variance_calibrator_tb;
  import ibv_pkg::*;

  localparam int DRAIN_CYCLES = 300;    // longer than the slowest request
  localparam int DOG_LIMIT    = 20000;  // idle cycles before giving up

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          dog = 0;
  bit          burst;   // no idling on either side while set

  ibv_in_if  req_if ();
  ibv_out_if res_if ();

  imu_bias_variance_calibrator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  ibv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .req          (req_if),
    .res          (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // One request; valid stays up after acceptance only when the next gap is 0.
  task automatic send(logic cmd, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                      logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.accel_x <= ax; req_if.accel_y <= ay; req_if.accel_z <= az;
    req_if.gyro_x  <= gx; req_if.gyro_y  <= gy; req_if.gyro_z  <= gz;
    do @(posedge clk_i); while (!req_if.ready);
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_all(logic [15:0] v);
    send(CMD_SAMPLE, v, v, v, v, v, v);
  endtask

  task automatic send_rand();
    send(($urandom_range(0, 19) == 0) ? CMD_RESTART : CMD_SAMPLE,
         16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Count writes happen only once the block has drained.
  task automatic write_count(logic [15:0] v);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Result side: random stall before each result.
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // Watchdog: any handshake or register write restarts the count.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i)
      dog <= 0;
    else
      dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [15:0] nval;
    burst         = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_SAMPLE;
    req_if.accel_x <= '0; req_if.accel_y <= '0; req_if.accel_z <= '0;
    req_if.gyro_x  <= '0; req_if.gyro_y  <= '0; req_if.gyro_z  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count of 3000 must hold off a result; lowering it mid-pass
    // ends the pass on the next sample.
    send_all(16'h7fff); send_all(16'h8000); send_all(16'h0000);
    write_count(16'd2);
    send_all(16'hffff);
    send_all(16'h0001); send_all(16'h8000);

    // Zero count behaves as one; extremes in both passes.
    write_count(16'd0);
    send_all(16'h7fff); send_all(16'h8000);
    send_all(16'h8000); send_all(16'h7fff);

    // Restart in the middle of a pass discards the partial sums.
    write_count(16'd3);
    send_all(16'h1234);
    send(CMD_RESTART, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_all(16'h0005); send_all(16'hfff0); send_all(16'h0100);

    // Saturated means: big count, pile up samples, then drop count to one.
    send(CMD_RESTART, '0, '0, '0, '0, '0, '0);
    write_count(16'hffff);
    repeat (4) send_all(16'h7fff);
    write_count(16'd1);
    send_all(16'h7fff);
    send_all(16'h8000);
    send(CMD_RESTART, '0, '0, '0, '0, '0, '0);
    write_count(16'hffff);
    repeat (4) send_all(16'h8000);
    write_count(16'd1);
    send_all(16'h8000);
    send_all(16'h7fff);

    // Random phase: mostly small counts so passes complete often.
    write_count(16'd4);
    for (int k = 0; k < 500; k++) begin
      if ($urandom_range(0, 49) == 0) burst = ~burst;
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 9))
          0:       nval = 16'd0;
          1:       nval = 16'hffff;
          2:       nval = 16'($urandom_range(9, 40));
          default: nval = 16'($urandom_range(1, 8));
        endcase
        write_count(nval);
      end
      send_rand();
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- imu_bias_variance_calibrator.f -----
design/ibv_pkg.sv
design/ibv_if.sv
design/ibv_div.sv
design/ibv_lane.sv
design/ibv_merge.sv
design/imu_bias_variance_calibrator.sv
tb/ibv_checker.sv
tb/imu_bias_variance_calibrator_tb.sv
